>>> rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds on every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/hcbp_pkg.sv
package hcbp_pkg;

  localparam int SYMBOLS      = 256;
  localparam int MAX_CODE_LEN = 32;
  localparam int SYM_W        = 8;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int TBL_AW       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int CODE_LIMIT   = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int ACC_W        = CODE_LIMIT + 7;
  localparam int TOT_W        = $clog2(ACC_W + 1);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int IN_TDATA_W   = ((SYM_W + CODE_W + LEN_W + 7) / 8) * 8;
  localparam int IN_TUSER_W   = 2;
  localparam int OUT_TDATA_W  = 8;
  localparam int OUT_TUSER_W  = 2;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

  typedef logic [LEN_W-1:0]   len_t;
  typedef logic [CODE_W-1:0]  bits_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [TOT_W-1:0]   tot_t;
  typedef logic [FIFO_CW-1:0] qcnt_t;

  typedef struct packed {
    logic [IN_TDATA_W-SYM_W-CODE_W-LEN_W-1:0] pad;
    len_t                                      code_len;
    bits_t                                     code_bits;
    logic [SYM_W-1:0]                          symbol;
  } in_data_t;

  typedef struct packed {
    len_t  len;
    bits_t bits;
  } code_t;

  typedef struct packed {
    logic  is_flush;
    code_t code;
  } qentry_t;

  typedef struct packed {
    logic stream_end;
    logic byte_valid;
  } out_user_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic bits_t len_mask(input len_t len);
    bits_t m;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (LEN_W'(i) < len);
    end
    return m;
  endfunction

endpackage

>>> rtl/hcbp_front.sv
module hcbp_front (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hcbp_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic [hcbp_pkg::IN_TUSER_W-1:0]    in_tuser,
  input  hcbp_pkg::qstat_t                   q_stat,
  output logic                               q_push,
  output hcbp_pkg::qentry_t                  q_entry
);

  hcbp_pkg::code_t           code_mem [hcbp_pkg::SYMBOLS];
  hcbp_pkg::code_t           rd_r;
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_flush_r;

  hcbp_pkg::in_data_t        din;
  hcbp_pkg::op_t             op;
  hcbp_pkg::len_t            len_c;
  hcbp_pkg::code_t           wr_code;
  logic [hcbp_pkg::TBL_AW-1:0] idx;
  logic                      accept, sym_ok;
  logic                      wr_en, rd_en, s1_take, take_flush;

  always_comb begin
    din     = hcbp_pkg::in_data_t'(in_tdata);
    op      = hcbp_pkg::op_t'(in_tuser);
    idx     = din.symbol[hcbp_pkg::TBL_AW-1:0];
    sym_ok  = ({1'b0, din.symbol} < (hcbp_pkg::SYM_W + 1)'(hcbp_pkg::SYMBOLS));
    len_c   = (din.code_len > hcbp_pkg::len_t'(hcbp_pkg::CODE_LIMIT)) ?
              hcbp_pkg::len_t'(hcbp_pkg::CODE_LIMIT) : din.code_len;
    wr_code = '{len: len_c, bits: din.code_bits & hcbp_pkg::len_mask(len_c)};

    q_push    = s1_valid_r && !q_stat.full;
    in_tready = !s1_valid_r || !q_stat.full;
    accept    = in_tvalid && in_tready;

    wr_en      = 1'b0;
    rd_en      = 1'b0;
    s1_take    = 1'b0;
    take_flush = 1'b0;
    if (accept) begin
      unique case (op)
        hcbp_pkg::OP_LOAD: begin
          wr_en = sym_ok;
        end
        hcbp_pkg::OP_ENCODE: begin
          rd_en   = sym_ok;
          s1_take = sym_ok;
        end
        hcbp_pkg::OP_FLUSH: begin
          s1_take    = 1'b1;
          take_flush = 1'b1;
        end
        default: ;
      endcase
    end

    if (s1_take) begin
      s1_valid_nxt = 1'b1;
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end

    q_entry = '{is_flush: s1_flush_r, code: rd_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      s1_flush_r <= take_flush;
    end
  end

  // code table: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      code_mem[idx] <= wr_code;
    end
    if (rd_en) begin
      rd_r <= code_mem[idx];
    end
  end

endmodule

>>> rtl/hcbp_fifo.sv
`include "assert_macros.svh"

module hcbp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  hcbp_pkg::qentry_t push_data,
  input  logic              pop,
  output hcbp_pkg::qentry_t head,
  output hcbp_pkg::qstat_t  stat
);

  hcbp_pkg::qentry_t           q_mem [hcbp_pkg::FIFO_DEPTH];
  logic [hcbp_pkg::FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [hcbp_pkg::FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  hcbp_pkg::qcnt_t              cnt_r, cnt_nxt;

  always_comb begin
    stat.full  = (cnt_r == hcbp_pkg::qcnt_t'(hcbp_pkg::FIFO_DEPTH));
    stat.empty = (cnt_r == '0);
    head       = q_mem[rd_ptr_r];

    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPLY(a_no_overflow, push, !stat.full, "queue push while full")
  `ASSERT_IMPLY(a_no_underflow, pop, !stat.empty, "queue pop while empty")

endmodule

>>> rtl/hcbp_back.sv
`include "assert_macros.svh"

module hcbp_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  hcbp_pkg::qentry_t                  head,
  input  hcbp_pkg::qstat_t                   q_stat,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hcbp_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tlast,
  output logic [hcbp_pkg::OUT_TUSER_W-1:0]   out_tuser
);

  hcbp_pkg::acc_t      acc_r, acc_nxt, m_acc;
  hcbp_pkg::tot_t      tot_r, tot_nxt, m_tot;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  logic                out_last_r;
  hcbp_pkg::out_user_t out_user_r;

  logic slot_free, idle, merge, emit_byte, flush_go;

  always_comb begin
    slot_free = !out_valid_r || out_tready;
    idle      = (tot_r < hcbp_pkg::tot_t'(8));
    merge     = idle && !q_stat.empty && !head.is_flush;
    flush_go  = idle && !q_stat.empty && head.is_flush && slot_free;
    pop       = merge || flush_go;

    if (merge) begin
      m_acc = acc_r | (hcbp_pkg::acc_t'(head.code.bits) << tot_r[2:0]);
      m_tot = tot_r + hcbp_pkg::tot_t'(head.code.len);
    end else begin
      m_acc = acc_r;
      m_tot = tot_r;
    end
    emit_byte = (m_tot >= hcbp_pkg::tot_t'(8)) && slot_free;

    if (flush_go) begin
      acc_nxt = '0;
      tot_nxt = '0;
    end else if (emit_byte) begin
      acc_nxt = m_acc >> 8;
      tot_nxt = m_tot - hcbp_pkg::tot_t'(8);
    end else begin
      acc_nxt = m_acc;
      tot_nxt = m_tot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      tot_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r <= acc_nxt;
      tot_r <= tot_nxt;
      if (emit_byte || flush_go) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit_byte) begin
      out_byte_r <= m_acc[7:0];
      out_last_r <= ((m_tot - hcbp_pkg::tot_t'(8)) < hcbp_pkg::tot_t'(8));
      out_user_r <= '{stream_end: 1'b0, byte_valid: 1'b1};
    end else if (flush_go) begin
      out_byte_r <= acc_r[7:0];
      out_last_r <= 1'b1;
      out_user_r <= '{stream_end: 1'b1, byte_valid: (tot_r != '0)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  `ASSERT_ALWAYS(a_tot_range, tot_r <= hcbp_pkg::tot_t'(hcbp_pkg::ACC_W), "bit count out of range")
  `ASSERT_IMPLY(a_pad_zero, idle, (acc_r >> tot_r) == '0, "stray bits above pending count")
  `ASSERT_NEXT(a_flush_clear, flush_go, tot_r == '0 && acc_r == '0, "flush left bits pending")

endmodule

>>> rtl/huffman_code_bit_packer_top.sv
// Channel | Dir | tdata                                   | tuser                      | tlast
// in_     | in  | [7:0] symbol, [39:8] code_bits,         | [1:0] opcode               | -
//         |     | [45:40] code_len, [47:46] zero          |                            |
// out_    | out | [7:0] out_byte                          | [0] byte_valid,            | last_of_run
//         |     |                                         | [1] stream_end             |
//
// Input takes one transaction per cycle unless s1 and the queue are both full; loads
// finish at the table write port. Encode and flush pass the s1 register and a 4-deep
// queue to the packer, which emits one byte per cycle while the output slot is free and
// merges a code only below 8 pending bits. Output stalls reach the input via the queue.
// rst_n is synchronous; the code table is not cleared and must be loaded before use.
module huffman_code_bit_packer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [hcbp_pkg::IN_TDATA_W-1:0]    in_tdata,   // symbol, code_bits, code_len
  input  logic [hcbp_pkg::IN_TUSER_W-1:0]    in_tuser,   // opcode
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hcbp_pkg::OUT_TDATA_W-1:0]   out_tdata,  // out_byte
  output logic                               out_tlast,
  output logic [hcbp_pkg::OUT_TUSER_W-1:0]   out_tuser   // byte_valid, stream_end
);

  hcbp_pkg::qstat_t  q_stat;
  hcbp_pkg::qentry_t q_entry, q_head;
  logic              q_push, q_pop;

  hcbp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_entry   (q_entry)
  );

  hcbp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_entry),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  hcbp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
